/* rtl/core/key_press_fade_tracker_top_defines.svh */
// Assertion macros for the key press fade tracker.
// Used by the top level; no other dependencies.
`ifndef KEY_PRESS_FADE_TRACKER_TOP_DEFINES_SVH
`define KEY_PRESS_FADE_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on the core clock, masked during reset
`define KPFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on the core clock, also during reset
`define KPFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KPFT_ASSERT(lbl, prop, msg)
`define KPFT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/kpft_pkg.sv */
// Shared constants, types and codes of the key press fade tracker.
// No dependencies.
package kpft_pkg;

  localparam int unsigned MaxActive = 32;
  localparam int unsigned IdxW      = $clog2(MaxActive);
  localparam int unsigned CntW      = $clog2(MaxActive + 1);
  localparam int unsigned KeyW      = 7;
  localparam int unsigned AgeW      = 16;
  localparam int unsigned AlphaW    = 8;
  localparam int unsigned ProdW     = AgeW + AlphaW;
  localparam int unsigned DivCntW   = $clog2(AlphaW + 1);
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [AgeW-1:0]   DefaultDuration = 16'd3000;
  localparam logic [AlphaW-1:0] DefaultPeak     = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DURATION = 1'b0,
    CFG_PEAK     = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_PRESS = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_MULT,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [AgeW-1:0] age;
  } entry_t;

endpackage

/* rtl/core/kpft_if.sv */
// Request and result channels of the key press fade tracker.
// Depends on kpft_pkg.
interface kpft_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [kpft_pkg::KeyW-1:0]   key_index;
  logic [kpft_pkg::AgeW-1:0]   elapsed_ms;

  modport source (output valid, func, key_index, elapsed_ms, input ready);
  modport sink   (input valid, func, key_index, elapsed_ms, output ready);
endinterface

interface kpft_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [kpft_pkg::KeyW-1:0]   out_key;
  logic [kpft_pkg::AlphaW-1:0] fade_alpha;
  logic                        last;

  modport source (output valid, out_key, fade_alpha, last, input ready);
  modport sink   (input valid, out_key, fade_alpha, last, output ready);
endinterface

/* rtl/core/kpft_div.sv */
// Restoring divider, one quotient bit per cycle, for the fade alpha.
// Depends on kpft_pkg. Dividend must stay below divisor * 2**AlphaW.
module kpft_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [kpft_pkg::ProdW-1:0]  dividend_i,
  input  logic [kpft_pkg::AgeW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [kpft_pkg::AlphaW-1:0] quot_o
);
  import kpft_pkg::*;

  logic [AgeW-1:0]    rem_q, rem_d;
  logic [AlphaW-1:0]  dvd_q, dvd_d;
  logic [AgeW-1:0]    dsr_q;
  logic [DivCntW-1:0] cnt_q;
  logic               done_q;
  logic [AgeW:0]      trial;
  logic               ge;

  // Shift in the next dividend bit and try a subtraction
  always_comb begin
    trial = {rem_q, dvd_q[AlphaW-1]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? AgeW'(trial - {1'b0, dsr_q}) : trial[AgeW-1:0];
    dvd_d = {dvd_q[AlphaW-2:0], ge};
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DivCntW'(AlphaW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - DivCntW'(1);
      done_q <= (cnt_q == DivCntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[ProdW-1:AlphaW];
      dvd_q <= dividend_i[AlphaW-1:0];
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

/* rtl/core/key_press_fade_tracker_top.sv */
// Key press fade tracker: list of recently pressed keys with fading alpha.
// Press: after the accept, entries are scanned (READ, CHECK) until the key is found
// and its fade restarted, or the list ends and the key is appended if there is room.
// Tick: entries pass READ, CHECK, MULT, the 8-step shared divider and a stallable EMIT.
// Reset empties the list and loads the default duration and peak alpha;
// the entry memory itself is not cleared. Depends on kpft_pkg, kpft_if, kpft_div.
`include "key_press_fade_tracker_top_defines.svh"

module key_press_fade_tracker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kpft_req_if.sink                      req_i,
  kpft_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [kpft_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kpft_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import kpft_pkg::*;

  // Configuration registers
  logic [AgeW-1:0]   dur_cfg_q;
  logic [AlphaW-1:0] peak_q;
  logic [AgeW-1:0]   dur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_cfg_q <= DefaultDuration;
      peak_q    <= DefaultPeak;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DURATION: dur_cfg_q <= cfg_wdata_i[AgeW-1:0];
        CFG_PEAK:     peak_q    <= cfg_wdata_i[AlphaW-1:0];
        default:      ;
      endcase
    end
  end

  // Zero duration falls back to the default
  assign dur = (dur_cfg_q == '0) ? DefaultDuration : dur_cfg_q;

  // Control and request registers
  state_e            state_q, state_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   kept_q, kept_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              func_q;
  logic [KeyW-1:0]   key_q;
  logic [AgeW-1:0]   ms_q;
  logic [AgeW-1:0]   diff_q, diff_d;
  logic [KeyW-1:0]   okey_q, okey_d;

  // Entry memory
  entry_t            mem [MaxActive];
  entry_t            rd_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;

  // Divider and output register
  logic              div_start;
  logic              div_done;
  logic [AlphaW-1:0] div_quot;
  logic [ProdW-1:0]  prod;
  logic              out_load;
  logic              out_valid_q;
  logic [KeyW-1:0]   out_key_q;
  logic [AlphaW-1:0] out_alpha_q;
  logic              out_last_q;

  logic              req_accept;
  logic              rsp_free;
  logic              scan_done;
  logic              is_last;
  logic [AgeW:0]     age_sum;
  logic [AgeW-1:0]   age_new;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;
  assign rsp_free    = !out_valid_q || rsp_o.ready;
  assign scan_done   = (idx_q == count_q);
  assign is_last     = ((idx_q + CntW'(1)) == count_q);

  // Advance age by the elapsed time, saturating at the duration
  assign age_sum = {1'b0, rd_q.age} + {1'b0, ms_q};
  assign age_new = (age_sum >= {1'b0, dur}) ? dur : age_sum[AgeW-1:0];

  // Sequencer: next state and memory, divider and output controls
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    kept_d    = kept_q;
    count_d   = count_q;
    diff_d    = diff_q;
    okey_d    = okey_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[IdxW-1:0];
    mem_wdata = '{key: key_q, age: '0};
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_accept) begin
          idx_d   = '0;
          kept_d  = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (scan_done) begin
          if (func_q == FUNC_PRESS) begin
            // Append a new key when there is room, else drop the press
            if (count_q < CntW'(MaxActive)) begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IdxW-1:0];
              count_d   = count_q + CntW'(1);
            end
          end else begin
            count_d = kept_q;
          end
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (func_q == FUNC_PRESS) begin
          if (rd_q.key == key_q) begin
            // Known key: restart its fade in place
            mem_we  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = ST_READ;
          end
        end else begin
          okey_d = rd_q.key;
          diff_d = dur - age_new;
          // Compact surviving entries toward the head of the list
          if (age_new != dur) begin
            mem_we    = 1'b1;
            mem_waddr = kept_q[IdxW-1:0];
            mem_wdata = '{key: rd_q.key, age: age_new};
            kept_d    = kept_q + CntW'(1);
          end
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (rsp_free) begin
          out_load = 1'b1;
          idx_d    = idx_q + CntW'(1);
          if (is_last) begin
            count_d = kept_q;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      kept_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      kept_q  <= kept_d;
      count_q <= count_d;
    end
  end

  // Request and per-entry payload
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      func_q <= req_i.func;
      key_q  <= req_i.key_index;
      ms_q   <= req_i.elapsed_ms;
    end
    diff_q <= diff_d;
    okey_q <= okey_d;
  end

  // Entry memory: one write port, registered read at the scan index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[idx_q[IdxW-1:0]];
  end

  // Scale remaining time by peak alpha; the divider registers the product
  assign prod = ProdW'(peak_q) * ProdW'(diff_q);

  kpft_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (dur),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Output register: hold a result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_key_q   <= okey_q;
      out_alpha_q <= div_quot;
      out_last_q  <= is_last;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.out_key    = out_key_q;
  assign rsp_o.fade_alpha = out_alpha_q;
  assign rsp_o.last       = out_last_q;

  // Checks
  `KPFT_ASSERT(a_quot_le_peak, div_done |-> (div_quot <= peak_q),
               "alpha quotient exceeds peak alpha")
  `KPFT_ASSERT(a_kept_trails_scan, (state_q == ST_READ && func_q == FUNC_TICK) |->
               (kept_q <= idx_q), "compaction index ran ahead of scan index")
  `KPFT_ASSERT(a_count_after_last, (out_load && is_last) |=> (count_q == $past(kept_q)),
               "list length not updated after final result")
  `KPFT_ASSERT_ALWAYS(a_count_bound, (!rst_ni) || (count_q <= CntW'(MaxActive)),
                      "list length exceeds capacity")

endmodule
